// File: design/gpp_pkg.sv
// Package for the Goldbach prime pair unit: widths, limits, FSM state types
// and the structs passed between the prime table and the pair scanner.
// No dependencies.
package gpp_pkg;

  // Field widths of the target and result requests
  localparam int TGT_W   = 9;
  localparam int PRIME_W = 8;

  // Default largest target accepted
  localparam int MAX_TARGET_DEF = 256;

  // Smallest even target that has a pair, and the first candidate prime
  localparam int MIN_TARGET  = 4;
  localparam int FIRST_PRIME = 2;

  // Prime table build sequencer
  typedef enum logic [1:0] {
    TB_TEST,
    TB_DIV,
    TB_READY
  } tbl_state_t;

  // Pair scanner
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_READ,
    SC_CHECK,
    SC_FLUSH
  } scan_state_t;

  // Lookup of two table entries, scanner to table
  typedef struct packed {
    logic               en;
    logic [PRIME_W-1:0] addr_p;
    logic [PRIME_W-1:0] addr_q;
  } tbl_rd_req_t;

  // Table status and registered read data, table to scanner
  typedef struct packed {
    logic ready;
    logic bit_p;
    logic bit_q;
  } tbl_status_t;

  // Remainder unit result
  typedef struct packed {
    logic done;
    logic zero;
  } div_res_t;

endpackage

// File: design/gpp_ifs.sv
// Valid/ready channels of the Goldbach prime pair unit.
// Depends on gpp_pkg for the field widths.
interface gpp_target_if;
  logic                      valid;
  logic                      ready;
  logic [gpp_pkg::TGT_W-1:0] target_value;

  modport source (output valid, output target_value, input ready);
  modport sink   (input valid, input target_value, output ready);
endinterface

interface gpp_result_if;
  logic                        valid;
  logic                        ready;
  logic [gpp_pkg::PRIME_W-1:0] first_prime;
  logic [gpp_pkg::PRIME_W-1:0] second_prime;
  logic [gpp_pkg::TGT_W-1:0]   pair_sum;
  logic                        pair_found;
  logic                        last_pair;

  modport source (output valid, output first_prime, output second_prime,
                  output pair_sum, output pair_found, output last_pair,
                  input ready);
  modport sink   (input valid, input first_prime, input second_prime,
                  input pair_sum, input pair_found, input last_pair,
                  output ready);
endinterface

// File: design/goldbach_prime_pairs_unit.sv
// Top level of the Goldbach prime pair unit: prime table and pair scanner.
// Depends on gpp_pkg, gpp_ifs, gpp_prime_table and gpp_pair_scan.
//
//   channel  | role | payload
//   ---------+------+-------------------------------------------------------
//   target   | sink | target_value
//   result   | src  | first_prime, second_prime, pair_sum, pair_found,
//            |      | last_pair
//
// After reset the prime table is built by trial division with one shared
// remainder unit; no request is taken until then. Each target is then scanned
// one candidate p at a time, each p passing through a table read state and a
// check state, since the table's read data is registered. A rejected target
// goes straight to the flush state and gives a single empty result.
// Results sit in an output register; a stalled result holds the scan when
// the next pair is found.
module goldbach_prime_pairs_unit #(
  parameter int MAX_TARGET = gpp_pkg::MAX_TARGET_DEF
) (
  input  logic         clk,
  input  logic         rst,
  gpp_target_if.sink   target,
  gpp_result_if.source result
);

  gpp_pkg::tbl_rd_req_t rd;
  gpp_pkg::tbl_status_t tbl;

  gpp_prime_table #(.MAX_TARGET(MAX_TARGET)) u_table (
    .clk    (clk),
    .rst    (rst),
    .rd     (rd),
    .status (tbl)
  );

  gpp_pair_scan #(.MAX_TARGET(MAX_TARGET)) u_scan (
    .clk    (clk),
    .rst    (rst),
    .target (target),
    .result (result),
    .rd     (rd),
    .tbl    (tbl)
  );

endmodule

// File: design/gpp_divider.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on gpp_pkg for the result struct.
module gpp_divider #(
  parameter int W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output gpp_pkg::div_res_t res
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvd_sh;
  logic [W-1:0]     dsr;
  logic [W:0]       rem_sh;
  logic [W:0]       rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem, dvd_sh[W-1]};
    if (rem_sh >= {1'b0, dsr}) begin
      rem_next = rem_sh - {1'b0, dsr};
    end else begin
      rem_next = rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      cnt    <= '0;
      rem    <= '0;
      dvd_sh <= dividend;
      dsr    <= divisor;
    end else if (busy) begin
      rem    <= rem_next[W-1:0];
      dvd_sh <= dvd_sh << 1;
      cnt    <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Final remainder is known during the last step
  assign res.done = busy && (cnt == CNT_W'(W - 1));
  assign res.zero = (rem_next[W-1:0] == '0);

endmodule

// File: design/gpp_prime_table.sv
// Primality table: one bit per number below MAX_TARGET, built after reset by
// trial division with the shared remainder unit, then read at two addresses.
// Depends on gpp_pkg and gpp_divider.
module gpp_prime_table #(
  parameter int MAX_TARGET = gpp_pkg::MAX_TARGET_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gpp_pkg::tbl_rd_req_t rd,
  output gpp_pkg::tbl_status_t status
);

  localparam int IDX_W = $clog2(MAX_TARGET);
  localparam int M_W   = IDX_W + 1;

  gpp_pkg::tbl_state_t state;
  gpp_pkg::tbl_state_t state_next;

  logic            mem [MAX_TARGET];
  logic [M_W-1:0]  m;
  logic [IDX_W-1:0] d;
  logic            bit_p;
  logic            bit_q;

  logic            wr_en;
  logic            wr_bit;
  logic            div_start;
  logic            m_inc;
  logic            d_inc;
  logic            m_end;
  logic            m_small;
  logic            d_past;
  gpp_pkg::div_res_t div_res;

  assign m_end   = (m == M_W'(MAX_TARGET));
  assign m_small = (m < M_W'(gpp_pkg::FIRST_PRIME));
  assign d_past  = ({1'b0, d} > (m >> 1));

  gpp_divider #(.W(IDX_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (m[IDX_W-1:0]),
    .divisor  (d),
    .res      (div_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gpp_pkg::TB_TEST: begin
        if (m_end) begin
          state_next = gpp_pkg::TB_READY;
        end else if (!m_small && !d_past) begin
          state_next = gpp_pkg::TB_DIV;
        end
      end
      gpp_pkg::TB_DIV: begin
        if (div_res.done) begin
          state_next = gpp_pkg::TB_TEST;
        end
      end
      gpp_pkg::TB_READY: state_next = gpp_pkg::TB_READY;
      default:           state_next = gpp_pkg::TB_TEST;
    endcase
  end

  // Sequencer strobes
  always_comb begin
    wr_en     = 1'b0;
    wr_bit    = 1'b0;
    div_start = 1'b0;
    m_inc     = 1'b0;
    d_inc     = 1'b0;
    unique case (state)
      gpp_pkg::TB_TEST: begin
        if (!m_end) begin
          if (m_small) begin
            wr_en = 1'b1;
            m_inc = 1'b1;
          end else if (d_past) begin
            // no divisor up to m/2: prime
            wr_en  = 1'b1;
            wr_bit = 1'b1;
            m_inc  = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      gpp_pkg::TB_DIV: begin
        if (div_res.done) begin
          if (div_res.zero) begin
            wr_en = 1'b1;
            m_inc = 1'b1;
          end else begin
            d_inc = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Candidate and divisor counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpp_pkg::TB_TEST;
      m     <= '0;
      d     <= IDX_W'(gpp_pkg::FIRST_PRIME);
    end else begin
      state <= state_next;
      if (m_inc) begin
        m <= m + M_W'(1);
        d <= IDX_W'(gpp_pkg::FIRST_PRIME);
      end else if (d_inc) begin
        d <= d + IDX_W'(1);
      end
    end
  end

  // Table memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[m[IDX_W-1:0]] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      bit_p <= mem[rd.addr_p[IDX_W-1:0]];
      bit_q <= mem[rd.addr_q[IDX_W-1:0]];
    end
  end

  assign status.ready = (state == gpp_pkg::TB_READY);
  assign status.bit_p = bit_p;
  assign status.bit_q = bit_q;

endmodule

// File: design/gpp_pair_scan.sv
// Pair scanner: walks p upwards for one target, looks up p and n-p in the
// prime table, holds one pair back to mark the last one, drives results.
// Depends on gpp_pkg and gpp_ifs.
module gpp_pair_scan #(
  parameter int MAX_TARGET = gpp_pkg::MAX_TARGET_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  gpp_target_if.sink           target,
  gpp_result_if.source         result,
  output gpp_pkg::tbl_rd_req_t rd,
  input  gpp_pkg::tbl_status_t tbl
);

  localparam int TW = gpp_pkg::TGT_W;
  localparam int PW = gpp_pkg::PRIME_W;

  gpp_pkg::scan_state_t state;
  gpp_pkg::scan_state_t state_next;

  logic [TW-1:0] n;
  logic [TW-1:0] p;
  logic [TW-1:0] q_cur;
  logic [TW-1:0] q_pend;
  logic          pend_valid;
  logic [PW-1:0] pend_p;

  logic accept;
  logic target_ok;
  logic slot_free;
  logic found;
  logic advance;
  logic push;
  logic p_done;

  assign accept    = target.valid && target.ready;
  assign target_ok = !target.target_value[0]
                     && (target.target_value >= TW'(gpp_pkg::MIN_TARGET))
                     && (target.target_value <= TW'(MAX_TARGET));
  assign slot_free = !result.valid || result.ready;
  assign found     = tbl.bit_p && tbl.bit_q;
  assign p_done    = (p == n);
  assign q_cur     = n - p;
  assign q_pend    = n - {1'b0, pend_p};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gpp_pkg::SC_IDLE: begin
        if (accept) begin
          state_next = target_ok ? gpp_pkg::SC_READ : gpp_pkg::SC_FLUSH;
        end
      end
      gpp_pkg::SC_READ:  state_next = p_done ? gpp_pkg::SC_FLUSH : gpp_pkg::SC_CHECK;
      gpp_pkg::SC_CHECK: state_next = advance ? gpp_pkg::SC_READ : gpp_pkg::SC_CHECK;
      gpp_pkg::SC_FLUSH: state_next = slot_free ? gpp_pkg::SC_IDLE : gpp_pkg::SC_FLUSH;
      default:           state_next = gpp_pkg::SC_IDLE;
    endcase
  end

  // Handshake, table lookup and push strobes
  always_comb begin
    target.ready = 1'b0;
    rd.en        = 1'b0;
    rd.addr_p    = p[PW-1:0];
    rd.addr_q    = q_cur[PW-1:0];
    advance      = 1'b0;
    push         = 1'b0;
    unique case (state)
      gpp_pkg::SC_IDLE:  target.ready = tbl.ready;
      gpp_pkg::SC_READ:  rd.en = !p_done;
      gpp_pkg::SC_CHECK: begin
        // a new pair displaces the held one, which needs a free slot
        advance = !found || !pend_valid || slot_free;
        push    = found && pend_valid && slot_free;
      end
      gpp_pkg::SC_FLUSH: push = slot_free;
      default: ;
    endcase
  end

  // Scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gpp_pkg::SC_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pend_valid <= 1'b0;
      end else if (advance && found) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n <= target.target_value;
      p <= TW'(gpp_pkg::FIRST_PRIME);
    end else if (advance) begin
      p <= p + TW'(1);
      if (found) begin
        pend_p <= p[PW-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (push) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (state == gpp_pkg::SC_FLUSH && !pend_valid) begin
        // odd, too small or too large target: single empty result
        result.first_prime  <= '0;
        result.second_prime <= '0;
        result.pair_sum     <= '0;
        result.pair_found   <= 1'b0;
        result.last_pair    <= 1'b1;
      end else begin
        result.first_prime  <= pend_p;
        result.second_prime <= q_pend[PW-1:0];
        result.pair_sum     <= n;
        result.pair_found   <= 1'b1;
        result.last_pair    <= (state == gpp_pkg::SC_FLUSH);
      end
    end
  end

endmodule
